// File: hdl/mmss_pkg.sv
// Shared types, constants and helper functions of the MM:SS countdown timer.
// No dependencies; the display and the controller use it by scoped names.
`default_nettype none

package mmss_pkg;

	// geometry
	localparam int DigitCount = 4;
	localparam int ScanW      = $clog2(DigitCount);
	localparam int DigitW     = 4;
	localparam int CountW     = 16;
	localparam int ByteW      = 8;

	// register reset values
	localparam logic [CountW-1:0] DebounceReset = 16'h01FF;
	localparam logic [CountW-1:0] TicksReset    = 16'd500;

	// digit places in the time word
	localparam int MinTens = 0;
	localparam int MinOnes = 1;
	localparam int SecTens = 2;
	localparam int SecOnes = 3;

	// display byte flags
	localparam logic [ByteW-1:0] BlinkFlag = 8'h40;
	localparam logic [ByteW-1:0] ColonFlag = 8'h40;

	typedef logic [DigitW-1:0] digit_t;
	typedef logic [DigitCount-1:0][DigitW-1:0] digits_t;
	typedef logic [CountW-1:0] count_t;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE_LIMIT     = 2'd0,
		CFG_TICKS_PER_SECOND   = 2'd1,
		CFG_PRESET_MINUTE_TENS = 2'd2,
		CFG_PRESET_MINUTE_ONES = 2'd3
	} cfg_index_t;

	// display control handed to the frame encoder
	typedef struct packed {
		logic refresh;
		logic running;
		logic blink;
	} disp_ctrl_t;

	// map an out-of-range digit to zero
	function automatic digit_t sane_digit(input digit_t v);
		return (v < 4'd10) ? v : 4'd0;
	endfunction

	// seven-segment pattern; codes above nine show as zero
	function automatic logic [ByteW-1:0] seg_pattern(input digit_t v);
		logic [ByteW-1:0] p;
		unique case (v)
			4'd1:    p = 8'h84;
			4'd2:    p = 8'h3D;
			4'd3:    p = 8'h9D;
			4'd4:    p = 8'h8E;
			4'd5:    p = 8'h9B;
			4'd6:    p = 8'hBB;
			4'd7:    p = 8'h85;
			4'd8:    p = 8'hBF;
			4'd9:    p = 8'h9F;
			default: p = 8'hB7;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mmss_in_if.sv
// Request channel into the timer: key levels, count tick and refresh request.
// Depends on nothing.
`default_nettype none

interface mmss_in_if;
	logic valid;
	logic ready;
	logic key_up_level;
	logic key_down_level;
	logic key_action_level;
	logic count_tick;
	logic refresh;

	modport source (
		output valid, key_up_level, key_down_level, key_action_level, count_tick, refresh,
		input  ready
	);
	modport sink (
		input  valid, key_up_level, key_down_level, key_action_level, count_tick, refresh,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/mmss_out_if.sv
// Result channel out of the timer: lamp, run state, digits and display bytes.
// Depends on nothing.
`default_nettype none

interface mmss_out_if;
	logic       valid;
	logic       ready;
	logic       lamp_on;
	logic       is_running;
	logic [3:0] minute_tens;
	logic [3:0] minute_ones;
	logic [2:0] second_tens;
	logic [3:0] second_ones;
	logic [7:0] digit_enable_byte;
	logic [7:0] segment_byte;
	logic       frame_valid;

	modport source (
		output valid, lamp_on, is_running, minute_tens, minute_ones, second_tens,
		       second_ones, digit_enable_byte, segment_byte, frame_valid,
		input  ready
	);
	modport sink (
		input  valid, lamp_on, is_running, minute_tens, minute_ones, second_tens,
		       second_ones, digit_enable_byte, segment_byte, frame_valid,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/mmss_display.sv
// Display frame encoder: digit select, segment pattern, blink and colon flags.
// Depends on mmss_pkg.
`default_nettype none

module mmss_display (
	input  wire mmss_pkg::disp_ctrl_t            ctrl,
	input  wire mmss_pkg::digits_t               digits,
	input  wire logic [mmss_pkg::ScanW-1:0]      scan_pos,
	output logic [mmss_pkg::ByteW-1:0]           digit_enable_byte,
	output logic [mmss_pkg::ByteW-1:0]           segment_byte,
	output logic                                 frame_valid,
	output logic [mmss_pkg::ScanW-1:0]           scan_next
);

	logic [mmss_pkg::ScanW-1:0]      idx;
	logic [mmss_pkg::DigitCount-1:0] sel;
	logic                            all_zero;

	// pick the digit shown at this scan position, rightmost first
	always_comb begin
		idx      = mmss_pkg::ScanW'(mmss_pkg::DigitCount - 1) - scan_pos;
		sel      = '0;
		sel[scan_pos] = 1'b1;
		all_zero = (digits == '0);
	end

	// on a refresh, build the two shifted bytes and advance the scan
	always_comb begin
		digit_enable_byte = '0;
		segment_byte      = '0;
		frame_valid       = 1'b0;
		scan_next         = scan_pos;
		if (ctrl.refresh) begin
			digit_enable_byte = {{(mmss_pkg::ByteW - mmss_pkg::DigitCount){1'b0}}, ~sel};
			segment_byte      = mmss_pkg::seg_pattern(digits[idx]);
			if (all_zero && ctrl.running && ctrl.blink) begin
				digit_enable_byte = digit_enable_byte | mmss_pkg::BlinkFlag;
				segment_byte      = '0;
			end
			if ((idx == mmss_pkg::ScanW'(mmss_pkg::MinOnes)) && ctrl.blink) begin
				segment_byte = segment_byte | mmss_pkg::ColonFlag;
			end
			frame_valid = 1'b1;
			scan_next   = scan_pos + 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/mm_ss_countdown_timer_controller_unit.sv
// MM:SS countdown timer controller: count tick, key poll and display refresh per request.
// Requests enter the input register; one pass of logic leads to the result register.
// Throughput: one request per cycle while the result channel is not stalled.
// A stalled result keeps one more request in the input register, then input ready drops.
// Reset (arst_n low): digits zero, blink set, idle, counters and scan cleared, debounce 511,
// 500 ticks per second. Depends on mmss_pkg, mmss_in_if, mmss_out_if and mmss_display.
`default_nettype none

module mm_ss_countdown_timer_controller_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mmss_in_if.sink                            in_ch,
	mmss_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [mmss_pkg::CountW-1:0]   cfg_data
);

	localparam mmss_pkg::count_t CountMax = '1;

	// input register
	logic valid_s1;
	logic up_s1, down_s1, action_s1, tick_s1, refresh_s1;

	// result register
	logic                          valid_s2;
	logic                          lamp_s2, run_s2;
	mmss_pkg::digits_t             digits_s2;
	logic [mmss_pkg::ByteW-1:0]    enable_s2, segment_s2;
	logic                          frame_s2;

	// running state and configuration
	mmss_pkg::count_t              debounce_q, tps_q;
	mmss_pkg::digits_t             time_q, saved_q;
	logic                          blink_q, run_q, lamp_q;
	mmss_pkg::count_t              sub_q;
	logic [mmss_pkg::ScanW-1:0]    scan_q;
	mmss_pkg::count_t              hold_up_q, hold_down_q, hold_act_q;

	// next state
	mmss_pkg::digits_t             time_d, saved_d;
	logic                          blink_d, run_d, lamp_d;
	mmss_pkg::count_t              sub_d, sub_inc;
	mmss_pkg::count_t              hold_up_d, hold_down_d, hold_act_d;
	logic                          up_low, down_low, act_low;
	logic [mmss_pkg::ScanW-1:0]    scan_d;
	logic [mmss_pkg::ByteW-1:0]    enable_d, segment_d;
	logic                          frame_d;
	mmss_pkg::disp_ctrl_t          disp_ctrl;
	mmss_pkg::cfg_index_t          cfg_sel;
	mmss_pkg::digit_t              cfg_digit;

	logic adv;

	assign adv          = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign cfg_sel      = mmss_pkg::cfg_index_t'(cfg_index);
	assign cfg_digit    = mmss_pkg::sane_digit(cfg_data[mmss_pkg::DigitW-1:0]);

	// count tick, then key poll
	always_comb begin
		time_d      = time_q;
		saved_d     = saved_q;
		blink_d     = blink_q;
		run_d       = run_q;
		lamp_d      = lamp_q;
		sub_d       = sub_q;
		hold_up_d   = hold_up_q;
		hold_down_d = hold_down_q;
		hold_act_d  = hold_act_q;
		up_low      = !up_s1;
		down_low    = !down_s1;
		act_low     = !action_s1;
		sub_inc     = sub_q + 1'b1;

		// count down one second every ticks_per_second ticks
		if (run_q && tick_s1) begin
			if (sub_inc == tps_q) begin
				sub_d = '0;
				if (time_q == '0) begin
					lamp_d = 1'b0;
				end else if (time_q[mmss_pkg::SecOnes] != '0) begin
					time_d[mmss_pkg::SecOnes] = time_q[mmss_pkg::SecOnes] - 1'b1;
				end else begin
					time_d[mmss_pkg::SecOnes] = 4'd9;
					if (time_q[mmss_pkg::SecTens] != '0) begin
						time_d[mmss_pkg::SecTens] = time_q[mmss_pkg::SecTens] - 1'b1;
					end else begin
						time_d[mmss_pkg::SecTens] = 4'd5;
						if (time_q[mmss_pkg::MinOnes] != '0) begin
							time_d[mmss_pkg::MinOnes] = time_q[mmss_pkg::MinOnes] - 1'b1;
						end else begin
							time_d[mmss_pkg::MinOnes] = 4'd9;
							time_d[mmss_pkg::MinTens] = time_q[mmss_pkg::MinTens] - 1'b1;
						end
					end
				end
				blink_d = !blink_q;
			end else begin
				sub_d = sub_inc;
			end
		end

		// up and down keys, up first, only while idle
		priority if (run_q) begin
			hold_up_d   = CountMax;
			hold_down_d = CountMax;
		end else if (up_low && (hold_up_q <= debounce_q)) begin
			hold_up_d = hold_up_q + 1'b1;
			if (hold_up_q == debounce_q) begin
				if (time_d[mmss_pkg::MinOnes] >= 4'd9) begin
					time_d[mmss_pkg::MinOnes] = '0;
					time_d[mmss_pkg::MinTens] = (time_d[mmss_pkg::MinTens] >= 4'd9) ?
						4'd0 : time_d[mmss_pkg::MinTens] + 1'b1;
				end else begin
					time_d[mmss_pkg::MinOnes] = time_d[mmss_pkg::MinOnes] + 1'b1;
				end
			end
		end else if (down_low && (hold_down_q <= debounce_q)) begin
			hold_down_d = hold_down_q + 1'b1;
			if (hold_down_q == debounce_q) begin
				if (time_d[mmss_pkg::MinOnes] == '0) begin
					time_d[mmss_pkg::MinOnes] = 4'd9;
					time_d[mmss_pkg::MinTens] = (time_d[mmss_pkg::MinTens] == '0) ?
						4'd9 : time_d[mmss_pkg::MinTens] - 1'b1;
				end else begin
					time_d[mmss_pkg::MinOnes] = time_d[mmss_pkg::MinOnes] - 1'b1;
				end
			end
		end else begin
			// no up or down press acts: hold the counts
			hold_up_d   = hold_up_q;
			hold_down_d = hold_down_q;
		end

		// action key: start saves the time, stop restores it
		if (act_low && (hold_act_q <= debounce_q)) begin
			hold_act_d = hold_act_q + 1'b1;
			if (hold_act_q == debounce_q) begin
				if (!run_q) begin
					saved_d = time_d;
					run_d   = 1'b1;
					lamp_d  = 1'b1;
				end else begin
					run_d   = 1'b0;
					lamp_d  = 1'b0;
					blink_d = 1'b1;
					time_d  = saved_q;
				end
			end
		end

		// drop hold counts of released keys
		if (!up_low)   hold_up_d   = '0;
		if (!down_low) hold_down_d = '0;
		if (!act_low)  hold_act_d  = '0;
	end

	assign disp_ctrl = '{refresh: refresh_s1, running: run_d, blink: blink_d};

	mmss_display u_display (
		.ctrl              (disp_ctrl),
		.digits            (time_d),
		.scan_pos          (scan_q),
		.digit_enable_byte (enable_d),
		.segment_byte      (segment_d),
		.frame_valid       (frame_d),
		.scan_next         (scan_d)
	);

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			up_s1      <= in_ch.key_up_level;
			down_s1    <= in_ch.key_down_level;
			action_s1  <= in_ch.key_action_level;
			tick_s1    <= in_ch.count_tick;
			refresh_s1 <= in_ch.refresh;
		end
	end

	// hold config and running state; writes must come only while idle, only presets are gated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= mmss_pkg::DebounceReset;
			tps_q       <= mmss_pkg::TicksReset;
			time_q      <= '0;
			saved_q     <= '0;
			blink_q     <= 1'b1;
			run_q       <= 1'b0;
			lamp_q      <= 1'b0;
			sub_q       <= '0;
			scan_q      <= '0;
			hold_up_q   <= '0;
			hold_down_q <= '0;
			hold_act_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				mmss_pkg::CFG_DEBOUNCE_LIMIT:   debounce_q <= cfg_data;
				mmss_pkg::CFG_TICKS_PER_SECOND: tps_q      <= cfg_data;
				mmss_pkg::CFG_PRESET_MINUTE_TENS: begin
					if (!run_q) begin
						time_q[mmss_pkg::MinTens]  <= cfg_digit;
						saved_q[mmss_pkg::MinTens] <= cfg_digit;
					end
				end
				mmss_pkg::CFG_PRESET_MINUTE_ONES: begin
					if (!run_q) begin
						time_q[mmss_pkg::MinOnes]  <= cfg_digit;
						saved_q[mmss_pkg::MinOnes] <= cfg_digit;
					end
				end
				default: ;
			endcase
		end else if (adv) begin
			time_q      <= time_d;
			saved_q     <= saved_d;
			blink_q     <= blink_d;
			run_q       <= run_d;
			lamp_q      <= lamp_d;
			sub_q       <= sub_d;
			scan_q      <= scan_d;
			hold_up_q   <= hold_up_d;
			hold_down_q <= hold_down_d;
			hold_act_q  <= hold_act_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lamp_s2    <= lamp_d;
			run_s2     <= run_d;
			digits_s2  <= time_d;
			enable_s2  <= enable_d;
			segment_s2 <= segment_d;
			frame_s2   <= frame_d;
		end
	end

	assign out_ch.valid             = valid_s2;
	assign out_ch.lamp_on           = lamp_s2;
	assign out_ch.is_running        = run_s2;
	assign out_ch.minute_tens       = digits_s2[mmss_pkg::MinTens];
	assign out_ch.minute_ones       = digits_s2[mmss_pkg::MinOnes];
	assign out_ch.second_tens       = digits_s2[mmss_pkg::SecTens][2:0];
	assign out_ch.second_ones       = digits_s2[mmss_pkg::SecOnes];
	assign out_ch.digit_enable_byte = enable_s2;
	assign out_ch.segment_byte      = segment_s2;
	assign out_ch.frame_valid       = frame_s2;

endmodule

`default_nettype wire

// File: hdl/mmss_checker.sv
// Port-level checks of the timer's result channel, bound to the top level.
// Depends on mm_ss_countdown_timer_controller_unit and its channel interfaces.
`default_nettype none

module mmss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       lamp_on,
	input wire logic       is_running,
	input wire logic [2:0] second_tens,
	input wire logic [7:0] digit_enable_byte,
	input wire logic [7:0] segment_byte,
	input wire logic       frame_valid
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_enable_byte)
		&& $stable(segment_byte) && $stable(lamp_on) && $stable(is_running))
		else $error("stalled result changed");

	// lamp only burns while the countdown runs
	a_lamp_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !lamp_on || is_running)
		else $error("lamp on while idle");

	// no frame, no display bytes
	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> digit_enable_byte == 8'h00 && segment_byte == 8'h00)
		else $error("display bytes without a frame");

	// a frame selects exactly one digit
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |-> $countones(digit_enable_byte[3:0]) == 3
		&& digit_enable_byte[7] == 1'b0 && digit_enable_byte[5:4] == 2'b00)
		else $error("bad digit select");

	// tens of seconds stay below six
	a_sec_tens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> second_tens <= 3'd5)
		else $error("tens of seconds out of range");

endmodule

bind mm_ss_countdown_timer_controller_unit mmss_checker u_mmss_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.lamp_on           (out_ch.lamp_on),
	.is_running        (out_ch.is_running),
	.second_tens       (out_ch.second_tens),
	.digit_enable_byte (out_ch.digit_enable_byte),
	.segment_byte      (out_ch.segment_byte),
	.frame_valid       (out_ch.frame_valid)
);

`default_nettype wire
